### rtl/infix_to_postfix_converter_assert.svh
// Assertion macros shared by the converter RTL.
// Included by the modules that carry checks; no other dependencies.
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS

`define ITP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itp assertion failed");

`define ITP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itp assertion failed");

`else

`define ITP_ASSERT_IMP(label, clk, rst, ante, cons)

`define ITP_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/itp_pkg.sv
// Shared types, codes and helper functions of the infix to postfix converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

   // input token codes
   localparam logic [3:0] TOK_END   = 4'd0;
   localparam logic [3:0] TOK_LIT   = 4'd1;
   localparam logic [3:0] TOK_IDENT = 4'd2;
   localparam logic [3:0] TOK_ADD   = 4'd3;
   localparam logic [3:0] TOK_SUB   = 4'd4;
   localparam logic [3:0] TOK_MUL   = 4'd5;
   localparam logic [3:0] TOK_DIV   = 4'd6;
   localparam logic [3:0] TOK_MOD   = 4'd7;
   localparam logic [3:0] TOK_POW   = 4'd8;
   localparam logic [3:0] TOK_OPEN  = 4'd9;
   localparam logic [3:0] TOK_CLOSE = 4'd10;
   localparam logic [3:0] TOK_COMMA = 4'd11;

   // output and stack entry kinds
   localparam logic [3:0] KIND_LIT  = 4'd0;
   localparam logic [3:0] KIND_VAR  = 4'd1;
   localparam logic [3:0] KIND_FUNC = 4'd2;
   localparam logic [3:0] KIND_ADD  = 4'd3;
   localparam logic [3:0] KIND_SUB  = 4'd4;
   localparam logic [3:0] KIND_MUL  = 4'd5;
   localparam logic [3:0] KIND_DIV  = 4'd6;
   localparam logic [3:0] KIND_MOD  = 4'd7;
   localparam logic [3:0] KIND_POW  = 4'd8;
   localparam logic [3:0] KIND_ERR  = 4'd9;
   localparam logic [3:0] KIND_END  = 4'd10;
   localparam logic [3:0] KIND_OPEN = 4'd11;

   // error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_COMMA    = 3'd1;
   localparam logic [2:0] ERR_CLOSE    = 3'd2;
   localparam logic [2:0] ERR_OPEN     = 3'd3;
   localparam logic [2:0] ERR_OVERFLOW = 3'd4;

   // emitted payloads never carry more than this many bits
   localparam int OUT_PAYLOAD_BITS = 16;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef enum logic [2:0] {
      CMD_END,
      CMD_LIT,
      CMD_IDENT,
      CMD_OP,
      CMD_OPEN,
      CMD_CLOSE,
      CMD_COMMA
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   op;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_IMP_POP,
      ST_VAR,
      ST_LIT,
      ST_IDENT,
      ST_OP_POP,
      ST_FUNC,
      ST_PUSH_OPEN,
      ST_CLOSE,
      ST_CLOSE_FN,
      ST_COMMA,
      ST_DRAIN
   } state_type;

   function automatic logic is_op(input logic [3:0] kind);
      return (kind >= KIND_ADD) && (kind <= KIND_POW);
   endfunction

   function automatic logic [1:0] op_rank(input logic [3:0] kind);
      logic [1:0] r;
      r = 2'd2;
      if (kind == KIND_ADD || kind == KIND_SUB) begin
         r = 2'd0;
      end else if (kind == KIND_MUL || kind == KIND_DIV || kind == KIND_MOD) begin
         r = 2'd1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/itp_req_if.sv
// Token input channel: valid/ready handshake with kind and payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface itp_req_if #(
   parameter int PAYLOAD_BITS = 16
);
   logic                    valid;
   logic                    ready;
   logic [3:0]              token_kind;
   logic [PAYLOAD_BITS-1:0] token_payload;

   modport source (output valid, output token_kind, output token_payload, input ready);
   modport sink   (input valid, input token_kind, input token_payload, output ready);
endinterface

`default_nettype wire

### rtl/itp_rsp_if.sv
// Postfix result channel: valid/ready handshake with kind, payload, error, last.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface itp_rsp_if #(
   parameter int PAYLOAD_BITS = 16
);
   logic                    valid;
   logic                    ready;
   logic [3:0]              out_kind;
   logic [PAYLOAD_BITS-1:0] out_payload;
   logic [2:0]              error_code;
   logic                    last_of_run;

   modport source (output valid, output out_kind, output out_payload, output error_code,
                   output last_of_run, input ready);
   modport sink   (input valid, input out_kind, input out_payload, input error_code,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

### rtl/infix_to_postfix_converter.sv
// Infix to postfix converter: top level joining the token front end and the stack back end.
// Depends on itp_pkg, itp_req_if, itp_rsp_if, itp_front and itp_back.
`timescale 1ns / 1ps
`default_nettype none

// Shunting-yard converter. Infix tokens enter on req_bus and land in a four-word
// command queue, unknown kinds are dropped there. The back end takes one token at a
// time: it dispatches the token, then emits its words and moves the stack in turn. An
// operator pops the stacked operators of equal or higher rank, a close or comma pops
// the entries above the open, and an end token drains the stack. The stack keeps its
// top entry in flops and the rest in a RAM of STACK_DEPTH - 1 words with one push or
// pop a cycle while the output is not stalled. A word waits in a hold register before
// it leaves, since its last_of_run flag is only known once the next word of the same
// token appears or the token completes. The stack needs no clearing pass; only entries
// below the count are read.
module infix_to_postfix_converter #(
   parameter int STACK_DEPTH  = 32,
   parameter int PAYLOAD_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   itp_req_if.sink   req_bus,
   itp_rsp_if.source rsp_bus
);

   itp_pkg::cmd_type        cmd;
   logic [PAYLOAD_BITS-1:0] cmd_payload;
   logic                    cmd_valid;
   logic                    cmd_take;

   itp_front #(
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .cmd         (cmd),
      .cmd_payload (cmd_payload),
      .cmd_valid   (cmd_valid),
      .cmd_take    (cmd_take)
   );

   itp_back #(
      .STACK_DEPTH  (STACK_DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cmd_payload (cmd_payload),
      .cmd_valid   (cmd_valid),
      .cmd_take    (cmd_take),
      .rsp_bus     (rsp_bus)
   );

endmodule

`default_nettype wire

### rtl/itp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module itp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/itp_front.sv
// Front end: accepts tokens, classifies them into commands, queues them.
// Depends on itp_pkg, itp_req_if and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "infix_to_postfix_converter_assert.svh"

module itp_front #(
   parameter int PAYLOAD_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   itp_req_if.sink                 req_bus,
   output itp_pkg::cmd_type        cmd,
   output logic [PAYLOAD_BITS-1:0] cmd_payload,
   output logic                    cmd_valid,
   input  logic                    cmd_take
);

   localparam int QueueCw = $clog2(itp_pkg::QUEUE_DEPTH + 1);

   itp_pkg::cmd_type        q_cmd_ff [itp_pkg::QUEUE_DEPTH];
   logic [PAYLOAD_BITS-1:0] q_pay_ff [itp_pkg::QUEUE_DEPTH];
   logic [itp_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [itp_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCw-1:0]           cnt_ff, cnt_in;

   itp_pkg::cmd_type dec_cmd;
   logic             dec_known;
   logic             accept;
   logic             push;

   // output kinds 3..8 use the same numbering as the operator tokens
   always_comb begin
      dec_known    = 1'b1;
      dec_cmd.kind = itp_pkg::CMD_END;
      dec_cmd.op   = req_bus.token_kind;
      unique case (req_bus.token_kind)
         itp_pkg::TOK_END:   dec_cmd.kind = itp_pkg::CMD_END;
         itp_pkg::TOK_LIT:   dec_cmd.kind = itp_pkg::CMD_LIT;
         itp_pkg::TOK_IDENT: dec_cmd.kind = itp_pkg::CMD_IDENT;
         itp_pkg::TOK_ADD, itp_pkg::TOK_SUB, itp_pkg::TOK_MUL,
         itp_pkg::TOK_DIV, itp_pkg::TOK_MOD, itp_pkg::TOK_POW: begin
            dec_cmd.kind = itp_pkg::CMD_OP;
         end
         itp_pkg::TOK_OPEN:  dec_cmd.kind = itp_pkg::CMD_OPEN;
         itp_pkg::TOK_CLOSE: dec_cmd.kind = itp_pkg::CMD_CLOSE;
         itp_pkg::TOK_COMMA: dec_cmd.kind = itp_pkg::CMD_COMMA;
         default:            dec_known    = 1'b0;
      endcase
   end

   assign req_bus.ready = (cnt_ff != QueueCw'(itp_pkg::QUEUE_DEPTH));
   assign accept        = req_bus.valid && req_bus.ready;
   // drop unknown kinds on acceptance
   assign push          = accept && dec_known;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + itp_pkg::QUEUE_AW'(1);
      end
      if (cmd_take) begin
         rd_ptr_in = rd_ptr_ff + itp_pkg::QUEUE_AW'(1);
      end
      if (push && !cmd_take) begin
         cnt_in = cnt_ff + QueueCw'(1);
      end else if (!push && cmd_take) begin
         cnt_in = cnt_ff - QueueCw'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_cmd_ff[wr_ptr_ff] <= dec_cmd;
         q_pay_ff[wr_ptr_ff] <= req_bus.token_payload;
      end
   end

   assign cmd         = q_cmd_ff[rd_ptr_ff];
   assign cmd_payload = q_pay_ff[rd_ptr_ff];
   assign cmd_valid   = (cnt_ff != '0);

   `ITP_ASSERT_NXT(a_drop_unknown, clock, reset, accept && !dec_known && !cmd_take, $stable(cnt_ff))
   `ITP_ASSERT_IMP(a_take_only_valid, clock, reset, cmd_take, cnt_ff != '0)

endmodule

`default_nettype wire

### rtl/itp_back.sv
// Back end: operator stack sequencer and result output stage.
// Depends on itp_pkg, itp_rsp_if, itp_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "infix_to_postfix_converter_assert.svh"

module itp_back #(
   parameter int STACK_DEPTH  = 32,
   parameter int PAYLOAD_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  itp_pkg::cmd_type        cmd,
   input  logic [PAYLOAD_BITS-1:0] cmd_payload,
   input  logic                    cmd_valid,
   output logic                    cmd_take,
   itp_rsp_if.source               rsp_bus
);

   localparam int CntW     = $clog2(STACK_DEPTH + 1);
   localparam int RamDepth = STACK_DEPTH - 1;
   localparam int RamAw    = $clog2(RamDepth);
   localparam int EntryW   = 4 + PAYLOAD_BITS;
   localparam int MaxRes   = STACK_DEPTH + 2;
   localparam int ResW     = $clog2(MaxRes + 1);
   localparam int KeepBits = (PAYLOAD_BITS < itp_pkg::OUT_PAYLOAD_BITS) ?
                             PAYLOAD_BITS : itp_pkg::OUT_PAYLOAD_BITS;
   localparam logic [PAYLOAD_BITS-1:0] PayMask =
      PAYLOAD_BITS'((64'd1 << KeepBits) - 64'd1);

   // sequencer state
   itp_pkg::state_type      state_ff, state_in;
   itp_pkg::cmd_type        cmd_ff;
   logic [PAYLOAD_BITS-1:0] pay_ff;
   logic                    resolve_ff;
   logic                    pend_v_ff;
   logic [PAYLOAD_BITS-1:0] pend_pay_ff;
   logic                    prev_lit_ff;
   logic [ResW-1:0]         res_cnt_ff;

   // stack: top entry in flops, the rest in RAM
   logic [CntW-1:0]         cnt_ff, cnt_in;
   logic [3:0]              top_kind_ff, top_kind_in;
   logic [PAYLOAD_BITS-1:0] top_pay_ff, top_pay_in;
   logic                    byp_v_ff;
   logic [EntryW-1:0]       byp_d_ff;
   logic [EntryW-1:0]       ram_rd;
   logic [EntryW-1:0]       sec;
   logic [CntW-1:0]         wr_diff, rd_diff;
   logic [RamAw-1:0]        rd_addr;
   logic                    ram_we;

   // result staging: hold waits for its last flag, rsp is the output register
   logic                    hold_v_ff;
   logic [3:0]              hold_kind_ff;
   logic [PAYLOAD_BITS-1:0] hold_pay_ff;
   logic [2:0]              hold_err_ff;
   logic                    rsp_v_ff;
   logic [3:0]              rsp_kind_ff;
   logic [PAYLOAD_BITS-1:0] rsp_pay_ff;
   logic [2:0]              rsp_err_ff;
   logic                    rsp_last_ff;

   // conditions
   logic go, out_free, top_v, top_open, top_func, full, room2, imp_pop, op_pop;
   logic resolve_hd, as_func_hd, prev_lit_hd;
   itp_pkg::state_type dispatch_state;

   // actions
   logic                    take, flush, set_pend, pop_v, clr_v, push_req, push_v;
   logic                    emit_v, emit_keep, out_load;
   logic [3:0]              emit_kind, push_kind;
   logic [PAYLOAD_BITS-1:0] emit_pay, push_pay;
   logic [2:0]              emit_err;

   function automatic itp_pkg::state_type main_state(input itp_pkg::cmd_kind_type k,
                                                     input logic as_func,
                                                     input logic lit);
      itp_pkg::state_type s;
      unique case (k)
         itp_pkg::CMD_END:   s = itp_pkg::ST_DRAIN;
         itp_pkg::CMD_LIT:   s = itp_pkg::ST_LIT;
         itp_pkg::CMD_IDENT: s = itp_pkg::ST_IDENT;
         itp_pkg::CMD_OP:    s = itp_pkg::ST_OP_POP;
         itp_pkg::CMD_OPEN: begin
            if (as_func) begin
               s = itp_pkg::ST_FUNC;
            end else if (lit) begin
               s = itp_pkg::ST_IMP_POP;
            end else begin
               s = itp_pkg::ST_PUSH_OPEN;
            end
         end
         itp_pkg::CMD_CLOSE: s = itp_pkg::ST_CLOSE;
         itp_pkg::CMD_COMMA: s = itp_pkg::ST_COMMA;
         default:            s = itp_pkg::ST_IDLE;
      endcase
      return s;
   endfunction

   itp_ram #(
      .WIDTH (EntryW),
      .DEPTH (RamDepth)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_diff[RamAw-1:0]),
      .wr_data ({top_kind_ff, top_pay_ff}),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   assign out_free = !rsp_v_ff || rsp_bus.ready;
   assign go       = !hold_v_ff || out_free;
   assign top_v    = (cnt_ff != '0);
   assign top_open = top_v && (top_kind_ff == itp_pkg::KIND_OPEN);
   assign top_func = top_v && (top_kind_ff == itp_pkg::KIND_FUNC);
   assign full     = (cnt_ff == CntW'(STACK_DEPTH));
   assign room2    = (cnt_ff <= CntW'(STACK_DEPTH - 2));
   assign imp_pop  = top_v && itp_pkg::is_op(top_kind_ff) &&
                     (itp_pkg::op_rank(top_kind_ff) >= itp_pkg::op_rank(itp_pkg::KIND_MUL));
   assign op_pop   = top_v && itp_pkg::is_op(top_kind_ff) &&
                     (itp_pkg::op_rank(top_kind_ff) >= itp_pkg::op_rank(cmd_ff.op));
   // entry just below the top; a push last cycle is not yet visible in the RAM read
   assign sec      = byp_v_ff ? byp_d_ff : ram_rd;

   // decisions taken from the queue head at dispatch
   assign resolve_hd = pend_v_ff && (cmd.kind != itp_pkg::CMD_OPEN);
   assign as_func_hd = pend_v_ff && (cmd.kind == itp_pkg::CMD_OPEN);
   assign dispatch_state = resolve_hd ?
                           (prev_lit_ff ? itp_pkg::ST_IMP_POP : itp_pkg::ST_VAR) :
                           main_state(cmd.kind, as_func_hd, prev_lit_ff);

   always_comb begin
      prev_lit_hd = (cmd.kind == itp_pkg::CMD_LIT);
      if (cmd.kind == itp_pkg::CMD_IDENT) begin
         prev_lit_hd = prev_lit_ff && !pend_v_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      if (go) begin
         unique case (state_ff)
            itp_pkg::ST_IDLE: begin
               if (cmd_valid) begin
                  state_in = dispatch_state;
               end
            end
            itp_pkg::ST_IMP_POP: begin
               if (!imp_pop) begin
                  state_in = resolve_ff ? itp_pkg::ST_VAR : itp_pkg::ST_PUSH_OPEN;
               end
            end
            itp_pkg::ST_VAR:       state_in = main_state(cmd_ff.kind, 1'b0, 1'b0);
            itp_pkg::ST_LIT:       state_in = itp_pkg::ST_IDLE;
            itp_pkg::ST_IDENT:     state_in = itp_pkg::ST_IDLE;
            itp_pkg::ST_OP_POP: begin
               if (!op_pop) begin
                  state_in = itp_pkg::ST_IDLE;
               end
            end
            itp_pkg::ST_FUNC: begin
               state_in = room2 ? itp_pkg::ST_PUSH_OPEN : itp_pkg::ST_IDLE;
            end
            itp_pkg::ST_PUSH_OPEN: state_in = itp_pkg::ST_IDLE;
            itp_pkg::ST_CLOSE: begin
               if (!top_v) begin
                  state_in = itp_pkg::ST_IDLE;
               end else if (top_open) begin
                  state_in = itp_pkg::ST_CLOSE_FN;
               end
            end
            itp_pkg::ST_CLOSE_FN:  state_in = itp_pkg::ST_IDLE;
            itp_pkg::ST_COMMA: begin
               if (!top_v || top_open) begin
                  state_in = itp_pkg::ST_IDLE;
               end
            end
            itp_pkg::ST_DRAIN: begin
               if (!top_v) begin
                  state_in = itp_pkg::ST_IDLE;
               end
            end
            default: state_in = itp_pkg::ST_IDLE;
         endcase
      end
   end

   // actions of the current state
   always_comb begin
      take      = 1'b0;
      flush     = 1'b0;
      set_pend  = 1'b0;
      pop_v     = 1'b0;
      clr_v     = 1'b0;
      push_req  = 1'b0;
      push_kind = itp_pkg::KIND_OPEN;
      push_pay  = '0;
      emit_v    = 1'b0;
      emit_kind = itp_pkg::KIND_LIT;
      emit_pay  = '0;
      emit_err  = itp_pkg::ERR_NONE;
      if (go) begin
         unique case (state_ff)
            itp_pkg::ST_IDLE: begin
               // whatever still sits in hold is the previous token's final word
               flush = hold_v_ff;
               take  = cmd_valid;
            end
            itp_pkg::ST_IMP_POP: begin
               if (imp_pop) begin
                  pop_v     = 1'b1;
                  emit_v    = 1'b1;
                  emit_kind = top_kind_ff;
                  emit_pay  = top_pay_ff;
               end else begin
                  push_req  = 1'b1;
                  push_kind = itp_pkg::KIND_MUL;
               end
            end
            itp_pkg::ST_VAR: begin
               emit_v    = 1'b1;
               emit_kind = itp_pkg::KIND_VAR;
               emit_pay  = pend_pay_ff;
            end
            itp_pkg::ST_LIT: begin
               emit_v    = 1'b1;
               emit_kind = itp_pkg::KIND_LIT;
               emit_pay  = pay_ff;
            end
            itp_pkg::ST_IDENT: set_pend = 1'b1;
            itp_pkg::ST_OP_POP: begin
               if (op_pop) begin
                  pop_v     = 1'b1;
                  emit_v    = 1'b1;
                  emit_kind = top_kind_ff;
                  emit_pay  = top_pay_ff;
               end else begin
                  push_req  = 1'b1;
                  push_kind = cmd_ff.op;
               end
            end
            itp_pkg::ST_FUNC: begin
               if (room2) begin
                  push_req  = 1'b1;
                  push_kind = itp_pkg::KIND_FUNC;
                  push_pay  = pend_pay_ff;
               end else begin
                  emit_v    = 1'b1;
                  emit_kind = itp_pkg::KIND_ERR;
                  emit_err  = itp_pkg::ERR_OVERFLOW;
               end
            end
            itp_pkg::ST_PUSH_OPEN: begin
               push_req  = 1'b1;
               push_kind = itp_pkg::KIND_OPEN;
            end
            itp_pkg::ST_CLOSE: begin
               if (!top_v) begin
                  emit_v    = 1'b1;
                  emit_kind = itp_pkg::KIND_ERR;
                  emit_err  = itp_pkg::ERR_CLOSE;
               end else if (top_open) begin
                  pop_v = 1'b1;
               end else begin
                  pop_v     = 1'b1;
                  emit_v    = 1'b1;
                  emit_kind = top_kind_ff;
                  emit_pay  = top_pay_ff;
               end
            end
            itp_pkg::ST_CLOSE_FN: begin
               if (top_func) begin
                  pop_v     = 1'b1;
                  emit_v    = 1'b1;
                  emit_kind = top_kind_ff;
                  emit_pay  = top_pay_ff;
               end
            end
            itp_pkg::ST_COMMA: begin
               if (!top_v) begin
                  emit_v    = 1'b1;
                  emit_kind = itp_pkg::KIND_ERR;
                  emit_err  = itp_pkg::ERR_COMMA;
               end else if (!top_open) begin
                  pop_v     = 1'b1;
                  emit_v    = 1'b1;
                  emit_kind = top_kind_ff;
                  emit_pay  = top_pay_ff;
               end
            end
            itp_pkg::ST_DRAIN: begin
               if (!top_v) begin
                  emit_v    = 1'b1;
                  emit_kind = itp_pkg::KIND_END;
               end else if (top_open) begin
                  // discard the rest of the stack
                  clr_v     = 1'b1;
                  emit_v    = 1'b1;
                  emit_kind = itp_pkg::KIND_ERR;
                  emit_err  = itp_pkg::ERR_OPEN;
               end else begin
                  pop_v     = 1'b1;
                  emit_v    = 1'b1;
                  emit_kind = top_kind_ff;
                  emit_pay  = top_pay_ff;
               end
            end
            default: ;
         endcase
      end
      push_v = push_req && !full;
      if (push_req && full) begin
         emit_v    = 1'b1;
         emit_kind = itp_pkg::KIND_ERR;
         emit_pay  = '0;
         emit_err  = itp_pkg::ERR_OVERFLOW;
      end
   end

   assign cmd_take  = take;
   // drop words past the per-token limit
   assign emit_keep = emit_v && (res_cnt_ff < ResW'(MaxRes));
   assign out_load  = flush || (emit_keep && hold_v_ff);

   // stack datapath
   always_comb begin
      cnt_in      = cnt_ff;
      top_kind_in = top_kind_ff;
      top_pay_in  = top_pay_ff;
      if (clr_v) begin
         cnt_in = '0;
      end else if (push_v) begin
         cnt_in      = cnt_ff + CntW'(1);
         top_kind_in = push_kind;
         top_pay_in  = push_pay;
      end else if (pop_v) begin
         cnt_in      = cnt_ff - CntW'(1);
         top_kind_in = sec[EntryW-1 -: 4];
         top_pay_in  = sec[PAYLOAD_BITS-1:0];
      end
      wr_diff = cnt_ff - CntW'(1);
      rd_diff = cnt_in - CntW'(2);
      rd_addr = (cnt_in >= CntW'(2)) ? rd_diff[RamAw-1:0] : '0;
   end

   assign ram_we = push_v && top_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= itp_pkg::ST_IDLE;
         cnt_ff      <= '0;
         pend_v_ff   <= 1'b0;
         pend_pay_ff <= '0;
         prev_lit_ff <= 1'b0;
         resolve_ff  <= 1'b0;
         res_cnt_ff  <= '0;
         byp_v_ff    <= 1'b0;
         hold_v_ff   <= 1'b0;
         rsp_v_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         byp_v_ff <= push_v;
         if (take) begin
            pend_v_ff   <= 1'b0;
            prev_lit_ff <= prev_lit_hd;
            resolve_ff  <= resolve_hd;
            res_cnt_ff  <= '0;
         end else if (emit_keep) begin
            res_cnt_ff <= res_cnt_ff + ResW'(1);
         end
         if (set_pend) begin
            pend_v_ff   <= 1'b1;
            pend_pay_ff <= pay_ff;
         end
         if (flush) begin
            hold_v_ff <= 1'b0;
         end else if (emit_keep) begin
            hold_v_ff <= 1'b1;
         end
         if (out_load) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      top_kind_ff <= top_kind_in;
      top_pay_ff  <= top_pay_in;
      byp_d_ff    <= {top_kind_ff, top_pay_ff};
      if (take) begin
         cmd_ff <= cmd;
         pay_ff <= cmd_payload;
      end
      if (emit_keep) begin
         hold_kind_ff <= emit_kind;
         hold_pay_ff  <= emit_pay & PayMask;
         hold_err_ff  <= emit_err;
      end
      if (out_load) begin
         rsp_kind_ff <= hold_kind_ff;
         rsp_pay_ff  <= hold_pay_ff;
         rsp_err_ff  <= hold_err_ff;
         rsp_last_ff <= flush;
      end
   end

   assign rsp_bus.valid       = rsp_v_ff;
   assign rsp_bus.out_kind    = rsp_kind_ff;
   assign rsp_bus.out_payload = rsp_pay_ff;
   assign rsp_bus.error_code  = rsp_err_ff;
   assign rsp_bus.last_of_run = rsp_last_ff;

   `ITP_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CntW'(STACK_DEPTH))
   `ITP_ASSERT_NXT(a_hold_kept, clock, reset, hold_v_ff && !out_free, hold_v_ff && $stable(hold_kind_ff))
   `ITP_ASSERT_IMP(a_err_marker, clock, reset, rsp_v_ff && (rsp_kind_ff != itp_pkg::KIND_ERR), rsp_err_ff == itp_pkg::ERR_NONE)
   `ITP_ASSERT_NXT(a_flush_on_take, clock, reset, take, !hold_v_ff)

endmodule

`default_nettype wire

### test/tb_infix_to_postfix_converter.sv
// Testbench for infix_to_postfix_converter: token sequences in, postfix words checked in order.
// Depends on itp_pkg, itp_req_if, itp_rsp_if and the converter RTL.
`timescale 1ns / 1ps

module tb_infix_to_postfix_converter;
   import itp_pkg::*;

   localparam int STACK_DEPTH  = 32;
   localparam int PAYLOAD_BITS = 16;
   localparam int MAX_WORDS    = 34;
   localparam int RANDOM_ITEMS = 280;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int TAIL_CYCLES  = 100;
   localparam int HOLDOFF_AT   = 100;
   localparam int HOLDOFF_LEN  = 600;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] payload;
      logic [2:0]  err;
      logic        last;
   } postfix_word_t;

   typedef struct {
      logic [3:0]  kind;
      logic [15:0] payload;
      bit          hold;
   } token_t;

   logic clock;
   logic reset;

   itp_req_if #(.PAYLOAD_BITS(PAYLOAD_BITS)) req_bus ();
   itp_rsp_if #(.PAYLOAD_BITS(PAYLOAD_BITS)) rsp_bus ();

   infix_to_postfix_converter #(
      .STACK_DEPTH (STACK_DEPTH),
      .PAYLOAD_BITS(PAYLOAD_BITS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------
   // Conversion predictor: operator stack, held name, literal flag
   // ---------------------------------------------------------------
   logic [3:0]  op_kind [STACK_DEPTH];
   logic [15:0] op_pay  [STACK_DEPTH];
   int          op_count;
   bit          name_held;
   logic [15:0] held_name;
   bit          after_literal;

   postfix_word_t token_words[$];
   postfix_word_t expected_words[$];

   function automatic int prec(input logic [3:0] kind);
      if (kind == KIND_ADD || kind == KIND_SUB) return 0;
      if (kind == KIND_MUL || kind == KIND_DIV || kind == KIND_MOD) return 1;
      return 2;
   endfunction

   task automatic add_word(input logic [3:0] kind, input logic [15:0] pay,
                           input logic [2:0] err);
      postfix_word_t w;
      w.kind = kind;
      w.payload = pay;
      w.err = err;
      w.last = 1'b0;
      if (token_words.size() < MAX_WORDS) token_words.push_back(w);
   endtask

   task automatic pop_word();
      op_count--;
      add_word(op_kind[op_count], op_pay[op_count], ERR_NONE);
   endtask

   task automatic pop_by_prec(input int r);
      while (op_count > 0 && op_kind[op_count-1] >= KIND_ADD &&
             op_kind[op_count-1] <= KIND_POW && r <= prec(op_kind[op_count-1]))
         pop_word();
   endtask

   task automatic push_entry(input logic [3:0] kind, input logic [15:0] pay);
      if (op_count >= STACK_DEPTH) begin
         add_word(KIND_ERR, '0, ERR_OVERFLOW);
      end else begin
         op_kind[op_count] = kind;
         op_pay[op_count] = pay;
         op_count++;
      end
   endtask

   task automatic insert_multiply();
      pop_by_prec(prec(KIND_MUL));
      push_entry(KIND_MUL, '0);
   endtask

   // pop operators until an open parenthesis is on top
   task automatic unwind_to_open(output bit found);
      found = 0;
      while (op_count > 0 && !found) begin
         if (op_kind[op_count-1] == KIND_OPEN) found = 1;
         else pop_word();
      end
   endtask

   task automatic convert_token(input logic [3:0] kind, input logic [15:0] pay);
      bit as_func;
      bit found;
      postfix_word_t w;
      as_func = 0;
      found = 0;
      if (kind > TOK_COMMA) return;
      token_words.delete();
      if (name_held) begin
         name_held = 0;
         if (kind == TOK_OPEN) begin
            as_func = 1;
         end else begin
            if (after_literal) insert_multiply();
            add_word(KIND_VAR, held_name, ERR_NONE);
         end
         after_literal = 0;
      end
      case (kind)
         TOK_END: begin
            while (op_count > 0 && !found) begin
               if (op_kind[op_count-1] == KIND_OPEN) begin
                  add_word(KIND_ERR, '0, ERR_OPEN);
                  found = 1;
               end else begin
                  pop_word();
               end
            end
            op_count = 0;
            add_word(KIND_END, '0, ERR_NONE);
         end
         TOK_LIT: add_word(KIND_LIT, pay, ERR_NONE);
         TOK_IDENT: begin
            name_held = 1;
            held_name = pay;
         end
         TOK_OPEN: begin
            if (as_func) begin
               // a function and its open go in together or not at all
               if (op_count + 2 > STACK_DEPTH) begin
                  add_word(KIND_ERR, '0, ERR_OVERFLOW);
               end else begin
                  push_entry(KIND_FUNC, held_name);
                  push_entry(KIND_OPEN, '0);
               end
            end else begin
               if (after_literal) insert_multiply();
               push_entry(KIND_OPEN, '0);
            end
         end
         TOK_CLOSE: begin
            unwind_to_open(found);
            if (found) begin
               op_count--;
               if (op_count > 0 && op_kind[op_count-1] == KIND_FUNC) pop_word();
            end else begin
               add_word(KIND_ERR, '0, ERR_CLOSE);
            end
         end
         TOK_COMMA: begin
            unwind_to_open(found);
            if (!found) add_word(KIND_ERR, '0, ERR_COMMA);
         end
         default: begin
            // operator token codes equal their stack kinds
            pop_by_prec(prec(kind));
            push_entry(kind, '0);
         end
      endcase
      if (kind == TOK_END) begin
         name_held = 0;
         held_name = '0;
         after_literal = 0;
      end else if (kind != TOK_IDENT) begin
         after_literal = (kind == TOK_LIT);
      end
      if (token_words.size() > 0) begin
         w = token_words.pop_back();
         w.last = 1'b1;
         token_words.push_back(w);
      end
      foreach (token_words[i]) expected_words.push_back(token_words[i]);
   endtask

   // ---------------------------------------------------------------
   // Stimulus plan
   // ---------------------------------------------------------------
   token_t token_plan[$];
   int     planned_items;

   function automatic logic [15:0] rand_pay();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic add_tok(input logic [3:0] kind, input logic [15:0] pay);
      token_t t;
      t.kind = kind;
      t.payload = pay;
      t.hold = 0;
      token_plan.push_back(t);
      if (kind <= TOK_COMMA) planned_items++;
   endtask

   task automatic add_hold();
      token_t t;
      t.kind = TOK_END;
      t.payload = '0;
      t.hold = 1;
      token_plan.push_back(t);
   endtask

   function automatic logic [3:0] rand_op();
      return 4'($urandom_range(TOK_ADD, TOK_POW));
   endfunction

   task automatic gen_term(input int depth);
      int n;
      case ($urandom_range(0, (depth > 0) ? 6 : 2))
         0: add_tok(TOK_LIT, rand_pay());
         1: add_tok(TOK_IDENT, rand_pay());
         2: begin
            add_tok(TOK_LIT, rand_pay());
            add_tok(TOK_IDENT, rand_pay());
         end
         3: begin
            add_tok(TOK_OPEN, '0);
            gen_expr(depth - 1);
            add_tok(TOK_CLOSE, '0);
         end
         4: begin
            add_tok(TOK_IDENT, rand_pay());
            add_tok(TOK_OPEN, '0);
            gen_expr(depth - 1);
            n = $urandom_range(0, 2);
            repeat (n) begin
               add_tok(TOK_COMMA, '0);
               gen_expr(depth - 1);
            end
            add_tok(TOK_CLOSE, '0);
         end
         5: begin
            add_tok(TOK_LIT, rand_pay());
            add_tok(TOK_OPEN, '0);
            gen_expr(depth - 1);
            add_tok(TOK_CLOSE, '0);
         end
         default: begin
            // function right after a literal: no implied multiply
            add_tok(TOK_LIT, rand_pay());
            add_tok(TOK_IDENT, rand_pay());
            add_tok(TOK_OPEN, '0);
            gen_expr(depth - 1);
            add_tok(TOK_CLOSE, '0);
         end
      endcase
   endtask

   task automatic gen_expr(input int depth);
      int n;
      gen_term(depth);
      n = $urandom_range(0, 3);
      repeat (n) begin
         add_tok(rand_op(), rand_pay());
         gen_term(depth);
      end
   endtask

   task automatic gen_broken();
      case ($urandom_range(0, 3))
         0: begin
            add_tok(TOK_OPEN, '0);
            gen_expr(1);
         end
         1: begin
            gen_expr(1);
            add_tok(TOK_CLOSE, '0);
            gen_expr(1);
         end
         2: begin
            gen_expr(1);
            add_tok(TOK_COMMA, '0);
            gen_expr(1);
         end
         default: begin
            gen_expr(1);
            add_tok(rand_op(), '0);
            add_tok(TOK_CLOSE, '0);
            add_tok(TOK_OPEN, '0);
            gen_expr(1);
         end
      endcase
      add_tok(TOK_END, rand_pay());
   endtask

   task automatic gen_noise();
      int n;
      n = $urandom_range(1, 8);
      repeat (n) add_tok(4'($urandom_range(0, 15)), rand_pay());
      add_tok(TOK_END, rand_pay());
   endtask

   // nest until the stack is full, then push more and unwind
   task automatic gen_deep();
      int pairs;
      int extra;
      int closes;
      pairs = $urandom_range(14, 17);
      extra = $urandom_range(0, 3);
      closes = $urandom_range(0, 40);
      repeat (pairs) begin
         add_tok(TOK_IDENT, rand_pay());
         add_tok(TOK_OPEN, '0);
      end
      repeat (extra) add_tok(TOK_OPEN, '0);
      add_tok(TOK_IDENT, rand_pay());
      add_tok(TOK_OPEN, '0);
      add_tok(TOK_LIT, rand_pay());
      add_tok(TOK_POW, '0);
      add_tok(TOK_LIT, rand_pay());
      add_tok(TOK_OPEN, '0);
      add_tok(TOK_LIT, rand_pay());
      repeat (closes) begin
         add_tok(TOK_CLOSE, '0);
         if ($urandom_range(0, 3) == 0) begin
            add_tok(rand_op(), '0);
            add_tok(TOK_LIT, rand_pay());
         end
      end
      add_tok(TOK_END, '0);
   endtask

   task automatic build_plan();
      int mid_hold;
      int limit;
      mid_hold = 0;
      // every operator back to back, from the widest literal to zero
      add_tok(TOK_LIT, 16'hFFFF);
      add_tok(TOK_ADD, '0);
      add_tok(TOK_SUB, '0);
      add_tok(TOK_MUL, '0);
      add_tok(TOK_DIV, '0);
      add_tok(TOK_MOD, '0);
      add_tok(TOK_POW, '0);
      add_tok(TOK_LIT, 16'h0000);
      // variable after literal, then a comma with no open
      add_tok(TOK_IDENT, 16'hA5A5);
      add_tok(TOK_COMMA, '0);
      add_tok(4'd12, 16'h1234);
      // open after literal, function with two arguments
      add_tok(TOK_LIT, 16'h0001);
      add_tok(TOK_OPEN, '0);
      add_tok(TOK_IDENT, 16'h5A5A);
      add_tok(TOK_OPEN, '0);
      add_tok(TOK_LIT, 16'h8000);
      add_tok(TOK_COMMA, '0);
      add_tok(TOK_LIT, 16'h7FFF);
      add_tok(TOK_CLOSE, '0);
      add_tok(TOK_CLOSE, '0);
      // close with no open, then an open left at end
      add_tok(TOK_CLOSE, '0);
      add_tok(4'd15, 16'hFFFF);
      add_tok(TOK_OPEN, '0);
      add_tok(TOK_END, '0);
      add_hold();

      limit = planned_items + RANDOM_ITEMS;
      gen_deep();
      while (planned_items < limit) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
               gen_expr(2);
               add_tok(TOK_END, rand_pay());
            end
            12, 13, 14: gen_broken();
            15, 16, 17: gen_noise();
            default: begin
               if ($urandom_range(0, 2) == 0) gen_deep();
               else gen_noise();
            end
         endcase
         if (!mid_hold && planned_items > limit - RANDOM_ITEMS / 2) begin
            add_hold();
            mid_hold = 1;
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Driver: bursts with random gaps, hold items wait for all words
   // ---------------------------------------------------------------
   int burst_left;
   int gap_left;
   int tokens_accepted;
   token_t next_tok;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left <= $urandom_range(1, 20);
         gap_left <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            convert_token(req_bus.token_kind, req_bus.token_payload);
            tokens_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (token_plan.size() > 0 && token_plan[0].hold) begin
               req_bus.valid <= 1'b0;
               if (expected_words.size() == 0) next_tok = token_plan.pop_front();
            end else if (gap_left > 0) begin
               req_bus.valid <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (token_plan.size() > 0) begin
               next_tok = token_plan.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.token_kind <= next_tok.kind;
               req_bus.token_payload <= next_tok.payload;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 20);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Receiver: ready pattern by mode, one long hold-off
   // ---------------------------------------------------------------
   int       holdoff_left;
   bit       holdoff_done;
   int       mode_left;
   int       ready_mode;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         holdoff_left <= 0;
         holdoff_done <= 0;
         mode_left <= 0;
         ready_mode <= 0;
      end else if (holdoff_left > 0) begin
         rsp_bus.ready <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else if (!holdoff_done && tokens_accepted >= HOLDOFF_AT) begin
         // stall long enough for the block to back up into its input
         rsp_bus.ready <= 1'b0;
         holdoff_left <= HOLDOFF_LEN;
         holdoff_done <= 1;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(10, 80);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (ready_mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
            2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_bus.ready <= ~rsp_bus.ready;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Monitor
   // ---------------------------------------------------------------
   int            mismatches;
   postfix_word_t want;

   task automatic compare_field(input string name, input int unsigned exp_val,
                                input int unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word: out_kind %0d out_payload %0d", rsp_bus.out_kind,
                   rsp_bus.out_payload);
            mismatches++;
         end else begin
            want = expected_words.pop_front();
            compare_field("out_kind", want.kind, rsp_bus.out_kind);
            compare_field("out_payload", want.payload, rsp_bus.out_payload);
            compare_field("error_code", want.err, rsp_bus.error_code);
            compare_field("last_of_run", want.last, rsp_bus.last_of_run);
         end
      end
   end

   int cycles;

   always @(posedge clock) cycles <= cycles + 1;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.token_kind = TOK_END;
      req_bus.token_payload = '0;
      rsp_bus.ready = 1'b0;
      cycles = 0;
      mismatches = 0;
      tokens_accepted = 0;
      planned_items = 0;
      op_count = 0;
      name_held = 0;
      held_name = '0;
      after_literal = 0;
      build_plan();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (cycles < CYCLE_LIMIT &&
             !(token_plan.size() == 0 && !req_bus.valid && expected_words.size() == 0))
         @(posedge clock);
      if (cycles < CYCLE_LIMIT) repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_words.size() != 0) begin
         $error("%0d expected words never arrived", expected_words.size());
         mismatches++;
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("infix_to_postfix_converter test failed");
      end else if (mismatches == 0) begin
         $display("infix_to_postfix_converter test passed");
      end else begin
         $display("infix_to_postfix_converter test failed");
      end
      $finish;
   end

endmodule
